### rtl/dvdsc_pkg.sv
// Shared constants, result kind codes and helpers for the DVD sector classifier.
package dvdsc_pkg;

  localparam int SECTOR_BYTES       = 2048;
  localparam int AUDIO_STREAMS      = 8;
  localparam int SUBPICTURE_STREAMS = 32;

  localparam int OFF_W = $clog2(SECTOR_BYTES);

  typedef enum logic [2:0] {
    KIND_NAV     = 3'd0,
    KIND_VIDEO   = 3'd1,
    KIND_AUDIO   = 3'd2,
    KIND_SUBPIC  = 3'd3,
    KIND_OTHER   = 3'd4,
    KIND_NO_UNIT = 3'd5
  } kind_t;

  localparam logic [7:0] ID_PRIVATE_1  = 8'hBD;
  localparam logic [7:0] ID_SYS_HEADER = 8'hBB;
  localparam logic [7:0] ID_PRIVATE_2  = 8'hBF;
  localparam logic [7:0] ID_PACK       = 8'hBA;
  localparam logic [7:0] ID_VIDEO_LO   = 8'hE0;
  localparam logic [7:0] ID_VIDEO_HI   = 8'hEF;
  localparam logic [7:0] ID_AUDIO_LO   = 8'hC0;
  localparam logic [7:0] ID_AUDIO_HI   = 8'hDF;
  localparam logic [7:0] SUB_SPU_LO    = 8'h20;
  localparam logic [7:0] SUB_SPU_HI    = 8'h3F;
  localparam logic [2:0] FRAME_B       = 3'd3;
  localparam logic [2:0] FRAME_NONE    = 3'd0;
  localparam logic [2:0] MASK_FULL     = 3'b111;
  localparam logic [31:0] PIC_START    = 32'h0000_0100;

  function automatic logic [2:0] lowest_clear(input logic [2:0] mask);
    logic [2:0] r;
    if (!mask[0])      r = 3'b001;
    else if (!mask[1]) r = 3'b010;
    else if (!mask[2]) r = 3'b100;
    else               r = 3'b000;
    return r;
  endfunction

  // Expected value of a byte at a fixed nav pack position; other positions accept any value.
  function automatic logic nav_byte_ok(input logic [OFF_W-1:0] off, input logic [7:0] b);
    logic ok;
    case (off)
      11'd0, 11'd1, 11'd14, 11'd15, 11'h26, 11'h27, 11'h400, 11'h401: ok = (b == 8'h00);
      11'd2, 11'd16, 11'h28, 11'h402:                                 ok = (b == 8'h01);
      11'd3:                                                          ok = (b == ID_PACK);
      11'd4:                                                          ok = (b[7:6] == 2'b01);
      11'd17:                                                         ok = (b == ID_SYS_HEADER);
      11'h29, 11'h403:                                                ok = (b == ID_PRIVATE_2);
      default:                                                        ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

### rtl/dvd_sector_stream_classifier.sv
// Top level: byte-serial DVD sector classifier with registered result.
// Usage:
//   Input channel (in_valid/in_ready) carries one program-stream byte per
//   request with the buffer's base sector and a buffer_end flag on its last
//   byte. Every 2048th byte of a sector yields one result request on the
//   output channel (out_valid/out_ready); other bytes yield nothing.
//   A byte is taken every cycle that in_ready is high: all per-byte work is
//   compares and counter updates done in one pass between the accepted byte
//   and the state and result registers. The result is registered and valid
//   in the cycle after the sector's last byte is accepted.
//   The result register holds one result. While it is full and the
//   receiver stalls, bytes keep flowing; only the byte that would complete
//   the next sector needs the slot, so in_ready drops only for that byte
//   until the waiting result is taken.
//   A buffer end in the middle of a sector drops that partial sector.
//   Reset (rst, synchronous) clears counters, unit tracking and the result
//   valid flag; results before the first nav pack report kind 5.
module dvd_sector_stream_classifier #(
  parameter int AUDIO_STREAMS = dvdsc_pkg::AUDIO_STREAMS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [31:0] base_sector,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  sector_kind,
  output logic [4:0]  stream_number,
  output logic [31:0] offset_in_unit,
  output logic        first_of_stream,
  output logic        id_out_of_range,
  output logic [2:0]  refs_marked_now,
  output logic [2:0]  refs_confirmed
);

  localparam int OW = dvdsc_pkg::OFF_W;
  localparam logic [OW-1:0] LAST_OFF = OW'(dvdsc_pkg::SECTOR_BYTES - 1);

  logic [OW-1:0] byte_offset, byte_offset_next;
  logic [31:0]   sector_index, sector_index_next;
  logic [39:0]   byte_history;
  logic [39:0]   header_fields, header_fields_next;
  logic          nav_match, nav_match_next;
  logic [31:0]   unit_start, unit_start_next;
  logic          unit_open, unit_open_next;
  logic [AUDIO_STREAMS-1:0] audio_seen, audio_seen_next;
  logic [31:0]   subpicture_seen, subpicture_seen_next;
  logic          video_seen, video_seen_next;
  logic [2:0]    last_frame_type, last_frame_type_next;
  logic [2:0]    ref_confirmed_mask, ref_confirmed_mask_next;
  logic          scan_on, scan_on_next;
  logic [2:0]    work_mask, work_mask_next;
  logic [2:0]    work_type, work_type_next;
  logic [2:0]    marks_now, marks_now_next;

  logic          in_acc, sector_done;
  logic [2:0]    r_kind, r_marked;
  logic [4:0]    r_num;
  logic [31:0]   r_offs;
  logic          r_first, r_oor;

  // only the sector's last byte needs a free result slot
  assign in_ready    = !out_valid || out_ready || (byte_offset != LAST_OFF);
  assign in_acc      = in_valid && in_ready;
  assign sector_done = in_acc && (byte_offset == LAST_OFF);

  always_comb begin
    logic [7:0]  b, hlen, stream, sub, p;
    logic [11:0] sub_pos;
    logic [16:0] endc;
    logic [2:0]  slot;
    logic [31:0] sector, aud32;
    logic [4:0]  num;
    b = data_byte;
    slot = '0;
    nav_match_next     = nav_match;
    header_fields_next = header_fields;
    scan_on_next       = scan_on;
    work_mask_next     = work_mask;
    work_type_next     = work_type;
    marks_now_next     = marks_now;
    if (byte_offset == '0) begin
      nav_match_next     = 1'b1;
      header_fields_next = '0;
      scan_on_next       = 1'b0;
      work_mask_next     = ref_confirmed_mask;
      work_type_next     = last_frame_type;
      marks_now_next     = '0;
    end
    if (!dvdsc_pkg::nav_byte_ok(byte_offset, b)) nav_match_next = 1'b0;

    hlen    = header_fields_next[15:8];
    sub_pos = 12'd23 + {4'd0, hlen};
    if (byte_offset == 11'd17) header_fields_next[7:0]   = b;
    if (byte_offset == 11'd18) header_fields_next[39:32] = b;
    if (byte_offset == 11'd19) header_fields_next[31:24] = b;
    if (byte_offset == 11'd22) header_fields_next[15:8]  = b;
    if (byte_offset > 11'd22 && {1'b0, byte_offset} == sub_pos)
      header_fields_next[23:16] = b;

    if (byte_offset == 11'd17 && b >= dvdsc_pkg::ID_VIDEO_LO && b <= dvdsc_pkg::ID_VIDEO_HI
        && unit_open && work_mask_next != dvdsc_pkg::MASK_FULL) begin
      scan_on_next = 1'b1;
      if (work_type_next != dvdsc_pkg::FRAME_B)
        marks_now_next = dvdsc_pkg::lowest_clear(work_mask_next);
    end

    // picture start code: 00 00 01 00, then the type sits two bytes on
    endc = 17'd20 + {1'b0, header_fields_next[39:24]};
    if (endc > 17'(dvdsc_pkg::SECTOR_BYTES)) endc = 17'(dvdsc_pkg::SECTOR_BYTES);
    if (scan_on_next && byte_offset >= 11'd23 && {1'b0, byte_offset} >= sub_pos
        && ({6'd0, byte_offset} + 17'd7) < endc
        && byte_history[39:8] == dvdsc_pkg::PIC_START) begin
      if (work_type_next != dvdsc_pkg::FRAME_B && work_type_next != dvdsc_pkg::FRAME_NONE) begin
        slot           = dvdsc_pkg::lowest_clear(work_mask_next);
        work_mask_next = work_mask_next | slot;
        marks_now_next = marks_now_next | slot;
      end
      work_type_next = b[5:3];
    end

    unit_start_next         = unit_start;
    unit_open_next          = unit_open;
    audio_seen_next         = audio_seen;
    subpicture_seen_next    = subpicture_seen;
    video_seen_next         = video_seen;
    last_frame_type_next    = last_frame_type;
    ref_confirmed_mask_next = ref_confirmed_mask;

    sector   = base_sector + sector_index;
    r_offs   = sector - unit_start;
    stream   = header_fields_next[7:0];
    sub      = header_fields_next[23:16];
    p        = stream;
    r_kind   = dvdsc_pkg::KIND_OTHER;
    r_num    = '0;
    r_first  = 1'b0;
    r_oor    = 1'b0;
    r_marked = '0;
    num      = '0;
    aud32    = 32'(audio_seen);
    if (nav_match_next) begin
      r_kind = dvdsc_pkg::KIND_NAV;
      r_offs = '0;
      unit_start_next         = sector;
      unit_open_next          = 1'b1;
      audio_seen_next         = '0;
      subpicture_seen_next    = '0;
      video_seen_next         = 1'b0;
      last_frame_type_next    = dvdsc_pkg::FRAME_NONE;
      ref_confirmed_mask_next = '0;
    end else if (!unit_open) begin
      r_kind = dvdsc_pkg::KIND_NO_UNIT;
      r_offs = '0;
    end else begin
      if (p >= dvdsc_pkg::ID_VIDEO_LO && p <= dvdsc_pkg::ID_VIDEO_HI)
        r_kind = dvdsc_pkg::KIND_VIDEO;
      else if (p >= dvdsc_pkg::ID_AUDIO_LO && p <= dvdsc_pkg::ID_AUDIO_HI)
        r_kind = dvdsc_pkg::KIND_AUDIO;
      else if (p == dvdsc_pkg::ID_PRIVATE_1) begin
        p = sub;
        if ((p >= 8'h80 && p <= 8'h8F) || (p >= 8'hA0 && p <= 8'hA7) ||
            (p >= dvdsc_pkg::ID_AUDIO_LO && p <= dvdsc_pkg::ID_AUDIO_HI))
          r_kind = dvdsc_pkg::KIND_AUDIO;
        else if (p >= dvdsc_pkg::SUB_SPU_LO && p <= dvdsc_pkg::SUB_SPU_HI)
          r_kind = dvdsc_pkg::KIND_SUBPIC;
      end
      case (r_kind)
        dvdsc_pkg::KIND_VIDEO: begin
          r_num           = 5'(p - dvdsc_pkg::ID_VIDEO_LO);
          r_first         = !video_seen;
          video_seen_next = 1'b1;
          if (scan_on_next) begin
            last_frame_type_next    = work_type_next;
            ref_confirmed_mask_next = work_mask_next;
            r_marked                = marks_now_next;
          end
        end
        dvdsc_pkg::KIND_AUDIO: begin
          if (p >= 8'h80 && p <= 8'h87)      num = 5'(p - 8'h80);
          else if (p >= 8'h88 && p <= 8'h8F) num = 5'(p - 8'h88);
          else if (p >= 8'hA0 && p <= 8'hBF) num = 5'(p - 8'hA0);
          else                               num = 5'(p - dvdsc_pkg::ID_AUDIO_LO);
          r_num = num;
          if (32'(num) >= 32'(AUDIO_STREAMS)) r_oor = 1'b1;
          else begin
            r_first         = !aud32[num];
            audio_seen_next = audio_seen | AUDIO_STREAMS'(32'd1 << num);
          end
        end
        dvdsc_pkg::KIND_SUBPIC: begin
          num                  = 5'(p - dvdsc_pkg::SUB_SPU_LO);
          r_num                = num;
          r_first              = !subpicture_seen[num];
          subpicture_seen_next = subpicture_seen | (32'd1 << num);
        end
        default: ;
      endcase
    end

    if (byte_offset == LAST_OFF) begin
      byte_offset_next  = '0;
      sector_index_next = sector_index + 32'd1;
    end else begin
      byte_offset_next  = byte_offset + OW'(1);
      sector_index_next = sector_index;
    end
    if (buffer_end) begin
      byte_offset_next  = '0;
      sector_index_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset        <= '0;
      sector_index       <= '0;
      byte_history       <= '0;
      header_fields      <= '0;
      nav_match          <= 1'b1;
      unit_start         <= '0;
      unit_open          <= 1'b0;
      audio_seen         <= '0;
      subpicture_seen    <= '0;
      video_seen         <= 1'b0;
      last_frame_type    <= dvdsc_pkg::FRAME_NONE;
      ref_confirmed_mask <= '0;
      scan_on            <= 1'b0;
      work_mask          <= '0;
      work_type          <= '0;
      marks_now          <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (in_acc) begin
        byte_offset   <= byte_offset_next;
        sector_index  <= sector_index_next;
        byte_history  <= {byte_history[31:0], data_byte};
        header_fields <= header_fields_next;
        nav_match     <= nav_match_next;
        scan_on       <= scan_on_next;
        work_mask     <= work_mask_next;
        work_type     <= work_type_next;
        marks_now     <= marks_now_next;
      end
      if (sector_done) begin
        unit_start         <= unit_start_next;
        unit_open          <= unit_open_next;
        audio_seen         <= audio_seen_next;
        subpicture_seen    <= subpicture_seen_next;
        video_seen         <= video_seen_next;
        last_frame_type    <= last_frame_type_next;
        ref_confirmed_mask <= ref_confirmed_mask_next;
      end
      if (sector_done)    out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sector_done) begin
      sector_kind     <= r_kind;
      stream_number   <= r_num;
      offset_in_unit  <= r_offs;
      first_of_stream <= r_first;
      id_out_of_range <= r_oor;
      refs_marked_now <= r_marked;
      refs_confirmed  <= ref_confirmed_mask_next;
    end
  end

  a_nav_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && sector_kind == dvdsc_pkg::KIND_NAV |-> offset_in_unit == '0)
    else $error("nav result with nonzero offset");

  a_no_unit_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && sector_kind == dvdsc_pkg::KIND_NO_UNIT
    |-> !first_of_stream && refs_marked_now == '0 && offset_in_unit == '0)
    else $error("result before first nav pack carries data");

  a_oor_audio: assert property (@(posedge clk) disable iff (rst)
    out_valid && id_out_of_range |-> sector_kind == dvdsc_pkg::KIND_AUDIO && !first_of_stream)
    else $error("out-of-range flag on non-audio or first-seen result");

  a_buffer_end_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && buffer_end |=> byte_offset == '0 && sector_index == '0)
    else $error("buffer end did not restart sector counters");

endmodule
